/* hw/rtl/tfd_pkg.sv */
// shared types, constants and the crc byte update for the telemetry frame decoder
// no dependencies; imported by every module of the block
package tfd_pkg;

    localparam int CHANNELS = 6;

    localparam logic [5:0] FRAME_BYTES = 6'd44;
    localparam logic [5:0] CRC_SPAN    = 6'd42;
    localparam logic [5:0] LAST_POS    = 6'd43;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // field boundaries, byte positions within the frame
    localparam logic [5:0] POS_STATION = 6'd4;
    localparam logic [5:0] POS_YEAR    = 6'd12;
    localparam logic [5:0] POS_DOY     = 6'd14;
    localparam logic [5:0] POS_CHAN    = 6'd16;
    localparam logic [5:0] POS_FLAGS   = 6'd40;
    localparam logic [3:0] CHAN_WORD0  = 4'd4;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_SHORT     = 2'd1,
        STATUS_BAD_MAGIC = 2'd2,
        STATUS_CRC_ERR   = 2'd3
    } status_t;

    // one byte request as classified by the front end
    typedef struct packed {
        logic [7:0] data;
        logic [5:0] pos;
        logic       last;
    } item_t;

    typedef struct packed {
        status_t                    status;
        logic [63:0]                station_id;
        logic [15:0]                year;
        logic [15:0]                day_of_year;
        logic [CHANNELS-1:0][31:0]  channel;
        logic [15:0]                quality_flags;
        logic [15:0]                received_crc;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* hw/rtl/tfd_front.sv */
// front end: accepts frame bytes and tags each with its saturating position
// depends on tfd_pkg
module tfd_front
    import tfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_data,
    input  logic       in_last,
    output logic       q_valid,
    input  logic       q_ready,
    output item_t      q_item
);

    logic [5:0] count_reg;
    logic [5:0] count_next;
    logic       push;

    assign in_ready = q_ready;
    assign push     = in_valid && q_ready;
    assign q_valid  = in_valid;

    always_comb
    begin
        q_item.data = in_data;
        q_item.pos  = count_reg;
        q_item.last = in_last;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push)
        begin
            if (in_last)
                count_next = 6'd0;
            else if (count_reg < FRAME_BYTES)
                count_next = count_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 6'd0;
        else
            count_reg <= count_next;
    end

endmodule

/* hw/rtl/tfd_queue.sv */
// two-entry queue between front end and back end
// depends on tfd_pkg
module tfd_queue
    import tfd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       wr_en;
    logic       rd_en;
    logic       wr_ptr;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign wr_en     = in_valid && in_ready;
    assign rd_en     = out_valid && out_ready;
    assign wr_ptr    = wr_ptr_reg;

    always_comb
    begin
        fill_next = fill_reg;
        if (wr_en && !rd_en)
            fill_next = fill_reg + 2'd1;
        else if (rd_en && !wr_en)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (wr_en)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr] <= in_item;
    end

endmodule

/* hw/rtl/tfd_back.sv */
// back end: field capture, running crc, status check and result register
// depends on tfd_pkg
module tfd_back
    import tfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] frame_magic,
    input  logic        q_valid,
    output logic        q_ready,
    input  item_t       q_item,
    output logic        res_valid,
    input  logic        res_ready,
    output result_t     res
);

    logic [31:0]               magic_reg,   magic_next;
    logic [63:0]               station_reg, station_next;
    logic [15:0]               year_reg,    year_next;
    logic [15:0]               doy_reg,     doy_next;
    logic [CHANNELS-1:0][31:0] chan_reg,    chan_next;
    logic [15:0]               flag_reg,    flag_next;
    logic [15:0]               rx_crc_reg,  rx_crc_next;
    logic [15:0]               crc_reg,     crc_next;
    logic                      out_valid_reg;
    result_t                   out_reg;
    result_t                   result;
    logic                      pop;
    logic [2:0]                ch_idx;
    logic [7:0]                b;
    logic [5:0]                p;

    // a closing byte needs room in the result register
    assign q_ready   = !q_item.last || !out_valid_reg || res_ready;
    assign pop       = q_valid && q_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign b         = q_item.data;
    assign p         = q_item.pos;
    assign ch_idx    = 3'(p[5:2] - CHAN_WORD0);

    always_comb
    begin
        magic_next   = magic_reg;
        station_next = station_reg;
        year_next    = year_reg;
        doy_next     = doy_reg;
        chan_next    = chan_reg;
        flag_next    = flag_reg;
        rx_crc_next  = rx_crc_reg;
        crc_next     = crc_reg;
        if (p < POS_STATION)
            magic_next = {magic_reg[23:0], b};
        else if (p < POS_YEAR)
            station_next = {station_reg[55:0], b};
        else if (p < POS_DOY)
            year_next = {year_reg[7:0], b};
        else if (p < POS_CHAN)
            doy_next = {doy_reg[7:0], b};
        else if (p < POS_FLAGS)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (ch_idx == 3'(i))
                    chan_next[i] = {chan_reg[i][23:0], b};
            end
        end
        else if (p < CRC_SPAN)
            flag_next = {flag_reg[7:0], b};
        else if (p < FRAME_BYTES)
            rx_crc_next = {rx_crc_reg[7:0], b};
        if (p < CRC_SPAN)
            crc_next = crc_byte(crc_reg, b);
    end

    always_comb
    begin
        result.station_id    = station_next;
        result.year          = year_next;
        result.day_of_year   = doy_next;
        result.channel       = chan_next;
        result.quality_flags = flag_next;
        result.received_crc  = rx_crc_next;
        if (p < LAST_POS)
            result.status = STATUS_SHORT;
        else if (magic_next != frame_magic)
            result.status = STATUS_BAD_MAGIC;
        else if (crc_next != rx_crc_next)
            result.status = STATUS_CRC_ERR;
        else
            result.status = STATUS_OK;
        if (result.status == STATUS_SHORT || result.status == STATUS_BAD_MAGIC)
        begin
            result.station_id    = '0;
            result.year          = '0;
            result.day_of_year   = '0;
            result.channel       = '0;
            result.quality_flags = '0;
            result.received_crc  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= '0;
            station_reg <= '0;
            year_reg    <= '0;
            doy_reg     <= '0;
            chan_reg    <= '0;
            flag_reg    <= '0;
            rx_crc_reg  <= '0;
            crc_reg     <= CRC_INIT;
        end
        else if (pop)
        begin
            if (q_item.last)
            begin
                magic_reg   <= '0;
                station_reg <= '0;
                year_reg    <= '0;
                doy_reg     <= '0;
                chan_reg    <= '0;
                flag_reg    <= '0;
                rx_crc_reg  <= '0;
                crc_reg     <= CRC_INIT;
            end
            else
            begin
                magic_reg   <= magic_next;
                station_reg <= station_next;
                year_reg    <= year_next;
                doy_reg     <= doy_next;
                chan_reg    <= chan_next;
                flag_reg    <= flag_next;
                rx_crc_reg  <= rx_crc_next;
                crc_reg     <= crc_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop && q_item.last)
            out_valid_reg <= 1'b1;
        else if (res_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_item.last)
            out_reg <= result;
    end

endmodule

/* hw/rtl/telemetry_frame_decoder_crc16.sv */
// top level of the telemetry frame decoder with crc-16 check
// depends on tfd_pkg, tfd_front, tfd_queue and tfd_back
//
// takes one frame byte per request on the s_ stream, s_tlast on the last byte
// of a frame, and gives one result request on the m_ stream for every frame.
// the block sustains one byte per clock cycle while the result side does not
// hold it off; the crc-16/ccitt-false byte update (init 0xffff, poly 0x1021)
// is combinational in the back end. m_tvalid rises once the last byte has
// passed through the two-entry queue and its result has been loaded into the
// result register. a held-off result stops s_tready once the closing byte of
// the next frame and one more byte wait. the front end keeps the saturating
// byte position, the back end captures the big-endian fields of a 44-byte
// frame, checks short frame, then magic, then crc, and clears for the next
// frame. the magic word resets to zero; the user must write it through
// cfg_we / cfg_wdata only while the block is idle; this is not enforced.
module telemetry_frame_decoder_crc16
    import tfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // configuration: expected magic word
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    // byte stream in
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tlast,   // frame_end
    // result stream out
    output logic         m_tvalid,
    input  logic         m_tready,
    // station_id[63:0], year[79:64], day_of_year[95:80], channel0..5[287:96],
    // quality_flags[303:288], received_crc[319:304]
    output logic [319:0] m_tdata,
    output logic [1:0]   m_tuser    // status
);

    logic [31:0] frame_magic_reg;
    logic        fq_valid;
    logic        fq_ready;
    item_t       fq_item;
    logic        qb_valid;
    logic        qb_ready;
    item_t       qb_item;
    result_t     res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_magic_reg <= 32'd0;
        else if (cfg_we)
            frame_magic_reg <= cfg_wdata;
    end

    // byte position tagging
    tfd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .in_last  (s_tlast),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_item   (fq_item)
    );

    // decouples byte intake from result back-pressure
    tfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    // capture, crc and status
    tfd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_magic (frame_magic_reg),
        .q_valid     (qb_valid),
        .q_ready     (qb_ready),
        .q_item      (qb_item),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    assign m_tuser = res.status;
    assign m_tdata = {res.received_crc, res.quality_flags, res.channel,
                      res.day_of_year, res.year, res.station_id};

endmodule

/* sim/telemetry_frame_decoder_crc16_test.sv */
`timescale 1ns / 100ps
// self-checking bench for telemetry_frame_decoder_crc16: frames in, decoded results out
// depends on tfd_pkg and the block's rtl; its own decoder model predicts every result

module telemetry_frame_decoder_crc16_test;
    import tfd_pkg::*;

    localparam int FULL_FRAME   = 44;
    localparam int RANDOM_BYTES = 1300;
    localparam int RANDOM_PHASES = 4;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 6;

    // kinds of frame the stimulus builds
    typedef enum int {
        FRM_GOOD,
        FRM_LONG,
        FRM_BAD_CRC,
        FRM_BAD_MAGIC,
        FRM_SHORT,
        FRM_NOISE
    } frame_kind_e;

    // how payload bytes are filled
    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES,
        FILL_EDGES
    } fill_e;

    // one decoded frame as it leaves the block
    typedef struct packed {
        status_t          status;
        logic [63:0]      station;
        logic [15:0]      year;
        logic [15:0]      doy;
        logic [5:0][31:0] chan;
        logic [15:0]      flags;
        logic [15:0]      rx_crc;
    } frame_report_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [319:0] m_tdata;
    logic [1:0]   m_tuser;

    // decoder model state, follows every accepted request
    logic [5:0]       frame_pos;
    logic [15:0]      run_crc;
    logic [31:0]      cap_magic;
    logic [63:0]      cap_station;
    logic [15:0]      cap_year;
    logic [15:0]      cap_doy;
    logic [5:0][31:0] cap_chan;
    logic [15:0]      cap_flags;
    logic [15:0]      cap_rx_crc;
    logic [31:0]      model_magic;

    frame_report_t expected_reports[$];
    logic [7:0]    frame_buf[$];

    logic [31:0] magic_now = '0;   // magic the stimulus believes is programmed
    bit          idle_on = 1'b1;   // random gaps and stalls enabled
    bit          hold_req = 1'b0;  // ask the receiver for one long hold-off
    int          errors = 0;
    int          bytes_seen = 0;
    int          frames_seen = 0;
    int          magic_writes = 0;
    int          status_seen[4] = '{0, 0, 0, 0};

    telemetry_frame_decoder_crc16 u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),      // data_byte
        .s_tlast   (s_tlast),      // frame_end
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),      // station_id, year, day_of_year, channel0..5,
                                   // quality_flags, received_crc
        .m_tuser   (m_tuser)       // status
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #15_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // crc-16/ccitt-false, shifted in one message bit at a time
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0};
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic clear_frame_state();
        frame_pos   = '0;
        run_crc     = CRC_INIT;
        cap_magic   = '0;
        cap_station = '0;
        cap_year    = '0;
        cap_doy     = '0;
        cap_chan    = '0;
        cap_flags   = '0;
        cap_rx_crc  = '0;
    endtask

    // absorb one accepted byte request; on the end marker queue the decoded frame
    task automatic decode_byte(input logic [7:0] b, input logic last);
        frame_report_t rep;
        int            ch;
        if (frame_pos < FRAME_BYTES)
        begin
            if (frame_pos < POS_STATION)
                cap_magic = {cap_magic[23:0], b};
            else if (frame_pos < POS_YEAR)
                cap_station = {cap_station[55:0], b};
            else if (frame_pos < POS_DOY)
                cap_year = {cap_year[7:0], b};
            else if (frame_pos < POS_CHAN)
                cap_doy = {cap_doy[7:0], b};
            else if (frame_pos < POS_FLAGS)
            begin
                ch = int'(frame_pos - POS_CHAN) / 4;
                cap_chan[ch] = {cap_chan[ch][23:0], b};
            end
            else if (frame_pos < CRC_SPAN)
                cap_flags = {cap_flags[7:0], b};
            else
                cap_rx_crc = {cap_rx_crc[7:0], b};
            // crc covers everything up to and including the flags word, not the crc itself
            if (frame_pos < CRC_SPAN)
                run_crc = crc16_step(run_crc, b);
            frame_pos = frame_pos + 6'd1;
        end
        // bytes beyond a full frame leave the captured fields alone
        if (last)
        begin
            rep = '0;
            if (frame_pos < FRAME_BYTES)
                rep.status = STATUS_SHORT;
            else if (cap_magic != model_magic)
                rep.status = STATUS_BAD_MAGIC;
            else if (run_crc != cap_rx_crc)
                rep.status = STATUS_CRC_ERR;
            else
                rep.status = STATUS_OK;
            // a crc error still reports the captured fields, short and bad magic do not
            if (rep.status == STATUS_OK || rep.status == STATUS_CRC_ERR)
            begin
                rep.station = cap_station;
                rep.year    = cap_year;
                rep.doy     = cap_doy;
                rep.chan    = cap_chan;
                rep.flags   = cap_flags;
                rep.rx_crc  = cap_rx_crc;
            end
            status_seen[rep.status]++;
            frames_seen++;
            expected_reports.push_back(rep);
            clear_frame_state();
        end
    endtask

    task automatic check_report();
        frame_report_t got;
        frame_report_t want;
        got.status  = status_t'(m_tuser);
        got.station = m_tdata[63:0];
        got.year    = m_tdata[79:64];
        got.doy     = m_tdata[95:80];
        got.chan    = m_tdata[287:96];
        got.flags   = m_tdata[303:288];
        got.rx_crc  = m_tdata[319:304];
        if (expected_reports.size() == 0)
        begin
            report_mismatch("result with no frame pending", {62'd0, m_tuser}, '0);
            return;
        end
        want = expected_reports.pop_front();
        if (got.status != want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.station != want.station)
            report_mismatch("station_id", got.station, want.station);
        if (got.year != want.year)
            report_mismatch("year", 64'(got.year), 64'(want.year));
        if (got.doy != want.doy)
            report_mismatch("day_of_year", 64'(got.doy), 64'(want.doy));
        for (int k = 0; k < CHANNELS; k++)
            if (got.chan[k] != want.chan[k])
                report_mismatch($sformatf("channel%0d", k), 64'(got.chan[k]),
                                64'(want.chan[k]));
        if (got.flags != want.flags)
            report_mismatch("quality_flags", 64'(got.flags), 64'(want.flags));
        if (got.rx_crc != want.rx_crc)
            report_mismatch("received_crc", 64'(got.rx_crc), 64'(want.rx_crc));
    endtask

    // one observer at the rising edge: register writes, byte requests, then results,
    // so the model never depends on process order within a step
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                model_magic = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                bytes_seen++;
                decode_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready)
                check_report();
        end
    end

    // result side: random stall bursts plus one long hold-off on request
    initial
    begin : receiver
        int stall_left;
        int hold_left;
        bit hold_taken;
        stall_left = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 18) - 1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // offer one byte request, called at a falling edge, returns at the falling edge
    // after the request was taken with tvalid still high
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    function automatic logic [7:0] pick_byte(input fill_e fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            FILL_EDGES:
                case ($urandom_range(0, 3))
                    0: return 8'h00;
                    1: return 8'hFF;
                    2: return 8'h80;
                    default: return 8'h7F;
                endcase
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // fill frame_buf; full-length good, long and bad kinds get the magic in front and a crc
    task automatic make_frame(input frame_kind_e kind, input fill_e fill, input int len);
        logic [31:0] magic;
        logic [31:0] mask;
        logic [15:0] crc;
        frame_buf.delete();
        for (int i = 0; i < len; i++)
            frame_buf.push_back(pick_byte(fill));
        if (len >= FULL_FRAME && kind != FRM_NOISE && kind != FRM_SHORT)
        begin
            magic = magic_now;
            if (kind == FRM_BAD_MAGIC)
            begin
                mask = $urandom;
                if (mask == 0)
                    mask = 32'd1;
                magic = magic ^ mask;
            end
            for (int i = 0; i < 4; i++)
                frame_buf[i] = magic[31 - 8 * i -: 8];
            crc = CRC_INIT;
            for (int i = 0; i < CRC_SPAN; i++)
                crc = crc16_step(crc, frame_buf[i]);
            if (kind == FRM_BAD_CRC)
                crc = crc ^ (16'h0001 << $urandom_range(0, 15));
            frame_buf[42] = crc[15:8];
            frame_buf[43] = crc[7:0];
        end
    endtask

    task automatic send_kind(input frame_kind_e kind, input fill_e fill, input int len);
        make_frame(kind, fill, len);
        send_frame();
    endtask

    // drop tvalid and let every pending result drain, plus the pipeline depth
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_magic(input logic [31:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        magic_now = value;
        magic_writes++;
    endtask

    // magic resets to zero, so a zero-magic frame must pass straight away
    task automatic test_reset_magic();
        send_kind(FRM_GOOD, FILL_RANDOM, FULL_FRAME);
        send_kind(FRM_GOOD, FILL_ZERO, FULL_FRAME);
        send_kind(FRM_SHORT, FILL_RANDOM, 1);
    endtask

    // every status, the length boundaries and the value extremes
    task automatic test_status_cases();
        write_magic(32'hFFFF_FFFF);
        send_kind(FRM_GOOD, FILL_ONES, FULL_FRAME);
        send_kind(FRM_GOOD, FILL_EDGES, FULL_FRAME);
        send_kind(FRM_BAD_MAGIC, FILL_RANDOM, FULL_FRAME);
        send_kind(FRM_BAD_CRC, FILL_RANDOM, FULL_FRAME);
        send_kind(FRM_SHORT, FILL_ONES, FULL_FRAME - 1);
        send_kind(FRM_LONG, FILL_EDGES, 63);
        send_kind(FRM_NOISE, FILL_RANDOM, 10);
        write_magic(32'h8000_0000);
        send_kind(FRM_GOOD, FILL_EDGES, FULL_FRAME);
        send_kind(FRM_BAD_CRC, FILL_ZERO, FULL_FRAME);
        send_kind(FRM_BAD_MAGIC, FILL_ONES, 50);
    endtask

    // receiver holds off while one-byte frames keep coming, so the block fills up
    task automatic test_backpressure();
        wait_idle();
        idle_on = 1'b0;
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
        for (int i = 0; i < 24; i++)
            send_kind(FRM_SHORT, FILL_RANDOM, 1);
        send_kind(FRM_GOOD, FILL_RANDOM, FULL_FRAME);
        idle_on = 1'b1;
    endtask

    // mostly well-formed frames with random content, the rest broken or noise;
    // a new magic per phase, and the last phase runs without gaps or stalls
    task automatic test_random();
        int          sent;
        int          pick;
        frame_kind_e kind;
        fill_e       fill;
        int          len;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_magic($urandom);
            idle_on = (phase < RANDOM_PHASES - 1);
            sent = 0;
            while (sent < RANDOM_BYTES / RANDOM_PHASES)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 11)
                    kind = FRM_GOOD;
                else if (pick < 13)
                    kind = FRM_LONG;
                else if (pick < 15)
                    kind = FRM_BAD_CRC;
                else if (pick < 17)
                    kind = FRM_BAD_MAGIC;
                else if (pick < 19)
                    kind = FRM_SHORT;
                else
                    kind = FRM_NOISE;
                case (kind)
                    FRM_LONG:  len = $urandom_range(FULL_FRAME + 1, 63);
                    FRM_SHORT: len = $urandom_range(1, FULL_FRAME - 1);
                    FRM_NOISE: len = $urandom_range(1, 63);
                    default:   len = FULL_FRAME;
                endcase
                fill = ($urandom_range(0, 9) < 7) ? FILL_RANDOM
                                                  : fill_e'($urandom_range(1, 3));
                send_kind(kind, fill, len);
                sent += len;
            end
        end
    endtask

    initial
    begin
        clear_frame_state();
        model_magic = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_magic();
        test_status_cases();
        test_backpressure();
        test_random();

        // drain with a bound, then give the pipeline time to show stray results
        s_tvalid <= 1'b0;
        for (int n = 0; n < 2000 && expected_reports.size() != 0; n++)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (expected_reports.size() != 0)
            report_mismatch("results never delivered", 64'(expected_reports.size()), '0);

        $display("run took %0d byte requests in %0d frames under %0d magic settings",
                 bytes_seen, frames_seen, magic_writes);
        $display("frame results: %0d ok, %0d short, %0d bad magic, %0d crc mismatch",
                 status_seen[STATUS_OK], status_seen[STATUS_SHORT],
                 status_seen[STATUS_BAD_MAGIC], status_seen[STATUS_CRC_ERR]);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
